// ===== rtl/core/nrmc_pkg.sv =====
// Package for the NMEA RMC sentence parser: character codes, register map,
// status codes and the hex digit decoder. No dependencies.
`default_nettype none

package nrmc_pkg;

  // Characters of the sentence framing
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_EAST   = 8'h45;
  localparam logic [7:0] CHAR_WEST   = 8'h57;

  // Expected header text, one character per header position
  localparam int unsigned HDR_LEN = 5;
  typedef logic [7:0] hdr_text_t [HDR_LEN];
  localparam hdr_text_t HDR_TEXT = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_SPEED  = 2'd0;
  localparam logic [1:0] REG_TRACK  = 2'd1;
  localparam logic [1:0] REG_MAGVAR = 2'd2;
  localparam logic [1:0] REG_HEMI   = 2'd3;

  localparam logic [3:0] SPEED_FIELD_RST  = 4'd7;
  localparam logic [3:0] TRACK_FIELD_RST  = 4'd8;
  localparam logic [3:0] MAGVAR_FIELD_RST = 4'd10;
  localparam logic [3:0] HEMI_FIELD_RST   = 4'd11;

  // Result status
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OTHER    = 2'd2;

  // Direction codes
  localparam logic [1:0] HEMI_EAST = 2'd0;
  localparam logic [1:0] HEMI_WEST = 2'd1;
  localparam logic [1:0] HEMI_BAD  = 2'd2;

  // Hex decoder result for a non-hex character
  localparam logic [4:0] NOT_HEX = 5'd16;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = c - 8'h57;
      end else begin
        v = {3'd0, NOT_HEX};
      end
      hex_value = v[4:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_rmc_sentence_parser.sv =====
// NMEA RMC sentence parser, top level: stream in/out, APB register port.
// Depends on nrmc_pkg.
//
// The block takes one ASCII character per transfer on the slave stream and
// gives one result per sentence on the master stream, valid once the second
// checksum character has passed through the input register and the sentence
// update into the output register. It takes a character every clock unless stalled:
// the character is captured in an input register and, from there, a single
// shallow update of the sentence state (XOR, comma count, decimal
// accumulators) is made. The only stall is when a sentence finishes while the
// previous result still sits unread in the output register. A '$' always
// restarts a sentence. Registers at byte addresses 0x0, 0x4, 0x8 and 0xC pick
// the comma count after which the speed, track, variation and E/W fields
// begin; write them only while no sentence is in flight.
`default_nettype none

module nmea_rmc_sentence_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [2] digit_error, [3] hemisphere_error, [17:4] speed_tenths,
  // [31:18] track_tenths, [46:32] variation_tenths, [54:47] received_sum,
  // [62:55] computed_sum, [63] zero
  output logic [63:0]      m_axis_tdata,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_HEX1, PH_HEX2} phase_e;

  // Field selection registers
  logic [3:0] speed_fld_q, track_fld_q, magvar_fld_q, hemi_fld_q;

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Sentence state
  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic        hdr_match_q, hdr_match_d;
  logic [7:0]  xor_q, xor_d;
  logic [3:0]  comma_q, comma_d;
  logic [2:0]  char_q, char_d;
  logic [13:0] speed_acc_q, speed_acc_d;
  logic [13:0] track_acc_q, track_acc_d;
  logic [13:0] var_acc_q, var_acc_d;
  logic [1:0]  hemi_q, hemi_d;
  logic        dbad_q, dbad_d;
  logic [4:0]  hi_nib_q, hi_nib_d;

  // Output register
  logic        out_vld_q;
  logic [63:0] out_data_q, out_data_d;
  logic        out_load;

  logic proc_ok, proc_fire, cfg_wr;

  // A character can be processed unless it may finish a sentence while the
  // output register is still full.
  assign proc_ok   = !out_vld_q || m_axis_tready || (phase_q != PH_HEX2);
  assign proc_fire = in_vld_q && proc_ok;
  assign s_axis_tready = !in_vld_q || proc_ok;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      nrmc_pkg::REG_SPEED:  prdata = {28'd0, speed_fld_q};
      nrmc_pkg::REG_TRACK:  prdata = {28'd0, track_fld_q};
      nrmc_pkg::REG_MAGVAR: prdata = {28'd0, magvar_fld_q};
      nrmc_pkg::REG_HEMI:   prdata = {28'd0, hemi_fld_q};
      default:              prdata = 32'd0;
    endcase
  end

  // Per-character update
  always_comb begin
    logic [7:0]  c;
    logic        num_cur, hemi_cur, is_digit;
    logic [3:0]  cnt_n, dval;
    logic [13:0] wval;
    logic [4:0]  lo_nib;
    logic [7:0]  rx;
    logic [1:0]  st;
    logic [14:0] var_s;

    c        = in_byte_q;
    num_cur  = (comma_q == speed_fld_q) || (comma_q == track_fld_q) ||
               (comma_q == magvar_fld_q);
    hemi_cur = (comma_q == hemi_fld_q);
    is_digit = (c >= nrmc_pkg::CHAR_ZERO) && (c <= nrmc_pkg::CHAR_NINE);
    dval     = is_digit ? c[3:0] : 4'd0;
    cnt_n    = (comma_q != 4'd15) ? comma_q + 4'd1 : comma_q;
    lo_nib   = nrmc_pkg::hex_value(c);
    rx       = 8'd0;
    st       = nrmc_pkg::ST_VALID;
    var_s    = 15'd0;

    case (char_q)
      3'd0:    wval = {10'd0, dval} * 14'd1000;
      3'd1:    wval = {10'd0, dval} * 14'd100;
      3'd2:    wval = {10'd0, dval} * 14'd10;
      default: wval = {10'd0, dval};
    endcase

    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    hdr_match_d = hdr_match_q;
    xor_d       = xor_q;
    comma_d     = comma_q;
    char_d      = char_q;
    speed_acc_d = speed_acc_q;
    track_acc_d = track_acc_q;
    var_acc_d   = var_acc_q;
    hemi_d      = hemi_q;
    dbad_d      = dbad_q;
    hi_nib_d    = hi_nib_q;
    out_load    = 1'b0;
    out_data_d  = out_data_q;

    if (c == nrmc_pkg::CHAR_DOLLAR) begin
      phase_d     = PH_BODY;
      hdr_pos_d   = 3'd0;
      hdr_match_d = 1'b1;
      xor_d       = 8'd0;
      comma_d     = 4'd0;
      char_d      = 3'd0;
      speed_acc_d = 14'd0;
      track_acc_d = 14'd0;
      var_acc_d   = 14'd0;
      hemi_d      = nrmc_pkg::HEMI_EAST;
      dbad_d      = 1'b0;
      hi_nib_d    = 5'd0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
        end
        PH_BODY: begin
          if (c == nrmc_pkg::CHAR_STAR) begin
            // close the last field
            if (num_cur && char_q >= 3'd1 && char_q <= 3'd4) dbad_d = 1'b1;
            if (hemi_cur && char_q == 3'd0) hemi_d = nrmc_pkg::HEMI_BAD;
            phase_d = PH_HEX1;
          end else begin
            xor_d = xor_q ^ c;
            if (hdr_pos_q < 3'(nrmc_pkg::HDR_LEN)) begin
              if (c != nrmc_pkg::HDR_TEXT[hdr_pos_q]) hdr_match_d = 1'b0;
              hdr_pos_d = hdr_pos_q + 3'd1;
            end
            if (c == nrmc_pkg::CHAR_COMMA) begin
              // close current field, then open the next (open wins on reuse)
              if (num_cur && char_q >= 3'd1 && char_q <= 3'd4) dbad_d = 1'b1;
              if (hemi_cur && char_q == 3'd0) hemi_d = nrmc_pkg::HEMI_BAD;
              comma_d = cnt_n;
              if (cnt_n == speed_fld_q)  speed_acc_d = 14'd0;
              if (cnt_n == track_fld_q)  track_acc_d = 14'd0;
              if (cnt_n == magvar_fld_q) var_acc_d   = 14'd0;
              if (cnt_n == hemi_fld_q)   hemi_d      = nrmc_pkg::HEMI_EAST;
              char_d = 3'd0;
            end else begin
              if (char_q < 3'd5) begin
                if (num_cur && char_q != 3'd3) begin
                  if (!is_digit) dbad_d = 1'b1;
                  if (comma_q == speed_fld_q)  speed_acc_d = speed_acc_q + wval;
                  if (comma_q == track_fld_q)  track_acc_d = track_acc_q + wval;
                  if (comma_q == magvar_fld_q) var_acc_d   = var_acc_q + wval;
                end
                if (hemi_cur && char_q == 3'd0) begin
                  if (c == nrmc_pkg::CHAR_EAST)      hemi_d = nrmc_pkg::HEMI_EAST;
                  else if (c == nrmc_pkg::CHAR_WEST) hemi_d = nrmc_pkg::HEMI_WEST;
                  else                               hemi_d = nrmc_pkg::HEMI_BAD;
                end
              end
              if (char_q != 3'd7) char_d = char_q + 3'd1;
            end
          end
        end
        PH_HEX1: begin
          hi_nib_d = lo_nib;
          phase_d  = PH_HEX2;
        end
        PH_HEX2: begin
          if (hi_nib_q == nrmc_pkg::NOT_HEX) rx = 8'd0;
          else if (lo_nib == nrmc_pkg::NOT_HEX) rx = {4'd0, hi_nib_q[3:0]};
          else rx = {hi_nib_q[3:0], lo_nib[3:0]};

          if (hdr_pos_q != 3'(nrmc_pkg::HDR_LEN) || !hdr_match_q) st = nrmc_pkg::ST_OTHER;
          else if (rx != xor_q) st = nrmc_pkg::ST_MISMATCH;
          else st = nrmc_pkg::ST_VALID;

          var_s = (hemi_q == nrmc_pkg::HEMI_WEST) ? 15'd0 - {1'b0, var_acc_q}
                                                  : {1'b0, var_acc_q};
          if (st == nrmc_pkg::ST_VALID) begin
            out_data_d = {1'b0, xor_q, rx, var_s, track_acc_q, speed_acc_q,
                          (hemi_q == nrmc_pkg::HEMI_BAD), dbad_q, st};
          end else begin
            out_data_d = {1'b0, xor_q, rx, 15'd0, 14'd0, 14'd0, 1'b0, 1'b0, st};
          end
          out_load = 1'b1;
          phase_d  = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_fld_q  <= nrmc_pkg::SPEED_FIELD_RST;
      track_fld_q  <= nrmc_pkg::TRACK_FIELD_RST;
      magvar_fld_q <= nrmc_pkg::MAGVAR_FIELD_RST;
      hemi_fld_q   <= nrmc_pkg::HEMI_FIELD_RST;
      in_vld_q     <= 1'b0;
      in_byte_q    <= 8'd0;
      phase_q      <= PH_IDLE;
      hdr_pos_q    <= 3'd0;
      hdr_match_q  <= 1'b1;
      xor_q        <= 8'd0;
      comma_q      <= 4'd0;
      char_q       <= 3'd0;
      speed_acc_q  <= 14'd0;
      track_acc_q  <= 14'd0;
      var_acc_q    <= 14'd0;
      hemi_q       <= nrmc_pkg::HEMI_EAST;
      dbad_q       <= 1'b0;
      hi_nib_q     <= 5'd0;
      out_vld_q    <= 1'b0;
      out_data_q   <= 64'd0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          nrmc_pkg::REG_SPEED:  speed_fld_q  <= pwdata[3:0];
          nrmc_pkg::REG_TRACK:  track_fld_q  <= pwdata[3:0];
          nrmc_pkg::REG_MAGVAR: magvar_fld_q <= pwdata[3:0];
          nrmc_pkg::REG_HEMI:   hemi_fld_q   <= pwdata[3:0];
          default: begin
          end
        endcase
      end

      // input register
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q  <= 1'b1;
        in_byte_q <= s_axis_tdata;
      end else if (proc_fire) begin
        in_vld_q  <= 1'b0;
      end

      // sentence state
      if (proc_fire) begin
        phase_q     <= phase_d;
        hdr_pos_q   <= hdr_pos_d;
        hdr_match_q <= hdr_match_d;
        xor_q       <= xor_d;
        comma_q     <= comma_d;
        char_q      <= char_d;
        speed_acc_q <= speed_acc_d;
        track_acc_q <= track_acc_d;
        var_acc_q   <= var_acc_d;
        hemi_q      <= hemi_d;
        dbad_q      <= dbad_d;
        hi_nib_q    <= hi_nib_d;
      end

      // output register
      if (proc_fire && out_load) begin
        out_vld_q  <= 1'b1;
        out_data_q <= out_data_d;
      end else if (m_axis_tready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(proc_fire && out_load && out_vld_q && !m_axis_tready))
    else $error("result overwritten while stalled");

  // After a result is produced the parser waits for the next '$'.
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && out_load) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after result");

  // Header position never runs past the header length.
  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= 3'(nrmc_pkg::HDR_LEN))
    else $error("header position out of range");

  // Accumulators stay within four decimal digits.
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed_acc_q <= 14'd9999) && (track_acc_q <= 14'd9999) && (var_acc_q <= 14'd9999))
    else $error("accumulator out of range");

  // A shown result never carries the unused status code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q[1:0] != 2'd3))
    else $error("bad status code");

endmodule

`default_nettype wire
